// ----- rtl/akc_pkg.sv -----
// Package for the alarm keypad controller: mode, event, feedback and
// register-index codes, plus the result record shared by the core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package akc_pkg;

  typedef enum logic [2:0] {
    MODE_INIT      = 3'd0,
    MODE_DISARMED  = 3'd1,
    MODE_PWDCHG    = 3'd2,
    MODE_ARMED     = 3'd3,
    MODE_INTRUSION = 3'd4,
    MODE_ALARM     = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    FUNC_TICK      = 3'd0,
    FUNC_KEY       = 3'd1,
    FUNC_TRIP      = 3'd2,
    FUNC_HEARTBEAT = 3'd3,
    FUNC_REPORT    = 3'd4,
    FUNC_ID_DONE   = 3'd5
  } func_t;

  typedef enum logic [2:0] {
    FB_NONE   = 3'd0,
    FB_DIGIT1 = 3'd1,
    FB_DIGIT2 = 3'd2,
    FB_DIGIT3 = 3'd3,
    FB_OK     = 3'd4,
    FB_WRONG  = 3'd5
  } feedback_t;

  typedef enum logic [1:0] {
    REG_PASSWORD    = 2'd0,
    REG_DELAY       = 2'd1,
    REG_WRONG_LIMIT = 2'd2,
    REG_NODE_ID     = 2'd3
  } reg_idx_t;

  localparam int unsigned DigitW   = 4;
  localparam int unsigned EntryLen = 4;
  localparam logic [4:0]  NoKey    = 5'd16;
  localparam logic [3:0]  WrongMax = 4'd15;
  localparam logic [15:0] DelayRst = 16'd100;
  localparam logic [3:0]  LimitRst = 4'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic       send_msg;
    logic [7:0] msg_node;
    logic       siren_on;
    logic [2:0] keypad_feedback;
    logic       entry_active;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/alarm_keypad_controller_core.sv -----
// Alarm keypad controller core: debounce, password entry, mode machine,
// broadcast flagging and a two-deep output buffer.
// Depends on akc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// One request in gives one result out. Each request is resolved in the
// cycle it is accepted, with the mode, debounce and delay state updated at
// that edge. Its result goes into the output register, or into the skid
// entry while the output register is held, so the core takes one request
// per cycle while in_stall is low; in_stall rises only when both are full,
// so a stalled consumer queues at most two results before input is held.
// Configuration writes are always ready and take effect at once; write them
// only while no request is in flight.
module alarm_keypad_controller_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic        in_key_present,
  input  wire logic [3:0]  in_key_code,
  input  wire logic [2:0]  in_reported_state,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_mode,
  output logic             out_send_msg,
  output logic [7:0]       out_msg_node,
  output logic             out_siren_on,
  output logic [2:0]       out_keypad_feedback,
  output logic             out_entry_active,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // configuration
  logic [15:0] password_r;
  logic [15:0] delay_cfg_r;
  logic [3:0]  wrong_limit_r;
  logic [7:0]  node_id_r;

  // controller state
  akc_pkg::mode_t mode_r, mode_nxt;
  akc_pkg::mode_t last_sent_r, last_sent_nxt;
  logic [3:0]  wrong_cnt_r, wrong_cnt_nxt;
  logic [4:0]  key_prev_r, key_prev_nxt;
  logic [4:0]  key_prev2_r, key_prev2_nxt;
  logic [akc_pkg::DigitW-1:0] digits_r [akc_pkg::EntryLen];
  logic [1:0]  typed_cnt_r, typed_cnt_nxt;
  logic [15:0] delay_cnt_r, delay_cnt_nxt;
  logic        delay_run_r, delay_run_nxt;

  // output buffer
  logic             out_valid_r, out_valid_nxt;
  akc_pkg::result_t out_data_r, out_data_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  akc_pkg::result_t skid_data_r, skid_data_nxt;

  logic in_fire, out_fire, cfg_fire;
  logic take;
  logic [4:0] sample;
  logic pwd_ok, pw_bad, expired, push, send;
  akc_pkg::feedback_t feedback;
  akc_pkg::mode_t m;
  akc_pkg::result_t res;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      password_r    <= '0;
      delay_cfg_r   <= akc_pkg::DelayRst;
      wrong_limit_r <= akc_pkg::LimitRst;
      node_id_r     <= '0;
    end else if (cfg_fire) begin
      unique case (akc_pkg::reg_idx_t'(cfg_index))
        akc_pkg::REG_PASSWORD:    password_r    <= cfg_data;
        akc_pkg::REG_DELAY:       delay_cfg_r   <= cfg_data;
        akc_pkg::REG_WRONG_LIMIT: wrong_limit_r <= cfg_data[3:0];
        akc_pkg::REG_NODE_ID:     node_id_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Resolve one request: event handling, then one pass of the mode machine.
  always_comb begin
    mode_nxt      = mode_r;
    last_sent_nxt = last_sent_r;
    wrong_cnt_nxt = wrong_cnt_r;
    key_prev_nxt  = key_prev_r;
    key_prev2_nxt = key_prev2_r;
    typed_cnt_nxt = typed_cnt_r;
    delay_cnt_nxt = delay_cnt_r;
    delay_run_nxt = delay_run_r;
    sample        = in_key_present ? {1'b0, in_key_code} : akc_pkg::NoKey;
    take          = 1'b0;
    pwd_ok        = 1'b0;
    pw_bad        = 1'b0;
    expired       = 1'b0;
    push          = 1'b0;
    send          = 1'b0;
    feedback      = akc_pkg::FB_NONE;

    unique case (in_func)
      akc_pkg::FUNC_TICK: begin
        if (delay_run_r) begin
          if (delay_cnt_r <= 16'd1) begin
            delay_cnt_nxt = '0;
            delay_run_nxt = 1'b0;
            mode_nxt      = akc_pkg::MODE_ALARM;
            expired       = 1'b1;
          end else begin
            delay_cnt_nxt = delay_cnt_r - 16'd1;
          end
        end
      end
      akc_pkg::FUNC_KEY: begin
        take          = in_key_present && sample == key_prev_r && sample != key_prev2_r;
        key_prev2_nxt = key_prev_r;
        key_prev_nxt  = sample;
        if (take) begin
          if (typed_cnt_r != 2'd3) begin
            typed_cnt_nxt = typed_cnt_r + 2'd1;
            feedback      = akc_pkg::feedback_t'({1'b0, typed_cnt_nxt});
          end else begin
            // fourth digit arrives on the port; the first three are stored
            typed_cnt_nxt = '0;
            if (digits_r[0] == password_r[3:0] && digits_r[1] == password_r[7:4] &&
                digits_r[2] == password_r[11:8] && in_key_code == password_r[15:12]) begin
              pwd_ok   = 1'b1;
              feedback = akc_pkg::FB_OK;
            end else begin
              pw_bad   = 1'b1;
              feedback = akc_pkg::FB_WRONG;
            end
          end
        end
      end
      akc_pkg::FUNC_REPORT: begin
        if (in_reported_state <= 3'(akc_pkg::MODE_ALARM))
          last_sent_nxt = akc_pkg::mode_t'(in_reported_state);
      end
      akc_pkg::FUNC_ID_DONE: begin
        if (mode_r == akc_pkg::MODE_INIT) begin
          mode_nxt      = akc_pkg::MODE_DISARMED;
          last_sent_nxt = akc_pkg::MODE_DISARMED;
        end
      end
      default: ;
    endcase

    m = mode_nxt;
    if (in_func == akc_pkg::FUNC_TRIP && m == akc_pkg::MODE_ARMED) begin
      m    = akc_pkg::MODE_INTRUSION;
      push = 1'b1;
    end
    if (pwd_ok) begin
      if (m == akc_pkg::MODE_DISARMED)
        m = akc_pkg::MODE_ARMED;
      else if (m == akc_pkg::MODE_ARMED || m == akc_pkg::MODE_INTRUSION ||
               m == akc_pkg::MODE_ALARM)
        m = akc_pkg::MODE_DISARMED;
      push = 1'b1;
    end else if (pw_bad && (m == akc_pkg::MODE_ARMED || m == akc_pkg::MODE_INTRUSION ||
                            m == akc_pkg::MODE_ALARM)) begin
      if (wrong_cnt_r != akc_pkg::WrongMax)
        wrong_cnt_nxt = wrong_cnt_r + 4'd1;
    end
    if (wrong_cnt_nxt > wrong_limit_r &&
        (m == akc_pkg::MODE_ARMED || m == akc_pkg::MODE_INTRUSION)) begin
      m    = akc_pkg::MODE_ALARM;
      push = 1'b1;
    end
    if (in_func == akc_pkg::FUNC_HEARTBEAT &&
        (m == akc_pkg::MODE_ARMED || m == akc_pkg::MODE_INTRUSION)) begin
      m    = akc_pkg::MODE_ALARM;
      push = 1'b1;
    end
    // adopt the network's view unless this node decided something itself
    if (last_sent_nxt != m && !push && !expired)
      m = last_sent_nxt;
    if (m != mode_r) begin
      if (m == akc_pkg::MODE_DISARMED) begin
        wrong_cnt_nxt = '0;
      end else if (m == akc_pkg::MODE_INTRUSION) begin
        delay_cnt_nxt = delay_cfg_r;
        delay_run_nxt = 1'b1;
      end
    end
    if (m != last_sent_nxt) begin
      send          = (m != akc_pkg::MODE_INIT);
      last_sent_nxt = m;
    end
    mode_nxt = m;

    res.mode            = 3'(m);
    res.send_msg        = send;
    res.msg_node        = send ? node_id_r : 8'd0;
    res.siren_on        = (m == akc_pkg::MODE_ALARM);
    res.keypad_feedback = 3'(feedback);
    res.entry_active    = (typed_cnt_nxt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= akc_pkg::MODE_INIT;
      last_sent_r <= akc_pkg::MODE_INIT;
      wrong_cnt_r <= '0;
      key_prev_r  <= akc_pkg::NoKey;
      key_prev2_r <= akc_pkg::NoKey;
      typed_cnt_r <= '0;
      delay_cnt_r <= '0;
      delay_run_r <= 1'b0;
    end else if (in_fire) begin
      mode_r      <= mode_nxt;
      last_sent_r <= last_sent_nxt;
      wrong_cnt_r <= wrong_cnt_nxt;
      key_prev_r  <= key_prev_nxt;
      key_prev2_r <= key_prev2_nxt;
      typed_cnt_r <= typed_cnt_nxt;
      delay_cnt_r <= delay_cnt_nxt;
      delay_run_r <= delay_run_nxt;
    end
  end

  // digit store: written only, never cleared
  always_ff @(posedge clk) begin
    if (in_fire && take)
      digits_r[typed_cnt_r] <= in_key_code;
  end

  // output register with skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_fire || !out_valid_r) begin
      out_valid_nxt  = skid_valid_r || in_fire;
      out_data_nxt   = skid_valid_r ? skid_data_r : res;
      skid_valid_nxt = 1'b0;
    end else if (in_fire) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_mode            = out_data_r.mode;
  assign out_send_msg        = out_data_r.send_msg;
  assign out_msg_node        = out_data_r.msg_node;
  assign out_siren_on        = out_data_r.siren_on;
  assign out_keypad_feedback = out_data_r.keypad_feedback;
  assign out_entry_active    = out_data_r.entry_active;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_no_init_broadcast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_send_msg) |-> (out_mode != 3'(akc_pkg::MODE_INIT)))
    else $error("broadcast flagged for init mode");

  a_entry_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_keypad_feedback == 3'(akc_pkg::FB_OK) ||
                   out_keypad_feedback == 3'(akc_pkg::FB_WRONG))) |-> !out_entry_active)
    else $error("entry still active after a full password was checked");

  a_node_only_on_send: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_send_msg) |-> (out_msg_node == 8'd0))
    else $error("node id shown without a broadcast");
`endif

endmodule

`default_nettype wire

// ----- tb/alarm_keypad_controller_core_tb.sv -----
// Self-checking bench for alarm_keypad_controller_core: a directed table, then random
// keypad entries and alarm events under several register settings, scored by a predictor unless a
// table row gives its own expectation. Depends on akc_pkg and the core RTL.
`timescale 1ns / 1ps

module alarm_keypad_controller_core_tb;
  import akc_pkg::*;

  localparam logic [2:0]  FuncSpareLo  = 3'd6;
  localparam logic [2:0]  FuncSpareHi  = 3'd7;
  localparam logic [2:0]  RepBadLo     = 3'd6;
  localparam logic [2:0]  RepBadHi     = 3'd7;
  localparam int unsigned DirRows      = 25;
  localparam int unsigned PhaseItems   = 190;
  localparam int unsigned HoldOffCyc   = 64;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned WatchdogNs   = 5_000_000;

  typedef struct {
    logic [2:0] func;
    logic       key_present;
    logic [3:0] key_code;
    logic [2:0] rep;
    logic       has_exp;
    result_t    exp;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic        in_key_present;
  logic [3:0]  in_key_code;
  logic [2:0]  in_reported_state;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_mode;
  logic        out_send_msg;
  logic [7:0]  out_msg_node;
  logic        out_siren_on;
  logic [2:0]  out_keypad_feedback;
  logic        out_entry_active;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // typed-in expectation travels with the request it belongs to
  logic        drv_has_exp;
  result_t     drv_exp;

  logic        idle_en;
  logic        pressure_req;
  logic [15:0] cur_pw;
  int unsigned n_offered;
  int unsigned n_results;
  int unsigned n_fail;
  int unsigned n_reports;
  int unsigned n_held;
  int unsigned n_bcast;
  int unsigned n_siren;
  int unsigned n_cfg;

  result_t     mode_results_q[$];
  dir_row_t    dir_tbl[DirRows];

  // predictor state and register copies
  mode_t       p_mode;
  mode_t       p_last_sent;
  logic [3:0]  p_wrong_cnt;
  logic [4:0]  p_smp_prev;
  logic [4:0]  p_smp_prev2;
  logic [3:0]  p_digits[EntryLen];
  logic [2:0]  p_typed;
  logic [15:0] p_dly_cnt;
  logic        p_dly_run;
  logic [15:0] p_pw;
  logic [15:0] p_dly;
  logic [3:0]  p_lim;
  logic [7:0]  p_nid;

  alarm_keypad_controller_core uut (.*);

  always #5 clk = ~clk;

  function automatic result_t predict_mode_step(input logic [2:0] f, input logic kp,
                                                input logic [3:0] kc, input logic [2:0] rep);
    mode_t     prev_m;
    mode_t     m;
    feedback_t fb;
    logic      trip, hb, expired, pw_ok, pw_bad, push, send, take;
    logic [4:0] smp;
    result_t   r;
    prev_m  = p_mode;
    fb      = FB_NONE;
    trip    = 1'b0;
    hb      = 1'b0;
    expired = 1'b0;
    pw_ok   = 1'b0;
    pw_bad  = 1'b0;
    push    = 1'b0;
    send    = 1'b0;
    case (f)
      FUNC_TICK: begin
        if (p_dly_run) begin
          if (p_dly_cnt <= 16'd1) begin
            p_dly_cnt = '0;
            p_dly_run = 1'b0;
            p_mode    = MODE_ALARM;
            expired   = 1'b1;
          end else begin
            p_dly_cnt = p_dly_cnt - 16'd1;
          end
        end
      end
      FUNC_KEY: begin
        smp  = kp ? {1'b0, kc} : NoKey;
        take = kp && smp == p_smp_prev && smp != p_smp_prev2;
        p_smp_prev2 = p_smp_prev;
        p_smp_prev  = smp;
        if (take) begin
          p_digits[p_typed[1:0]] = kc;
          p_typed = p_typed + 3'd1;
          if (p_typed < EntryLen) begin
            fb = feedback_t'(p_typed);
          end else begin
            if ({p_digits[3], p_digits[2], p_digits[1], p_digits[0]} == p_pw) begin
              pw_ok = 1'b1;
              fb    = FB_OK;
            end else begin
              pw_bad = 1'b1;
              fb     = FB_WRONG;
            end
            p_typed = '0;
          end
        end
      end
      FUNC_TRIP:      trip = 1'b1;
      FUNC_HEARTBEAT: hb = 1'b1;
      FUNC_REPORT: begin
        if (rep <= MODE_ALARM) p_last_sent = mode_t'(rep);
      end
      FUNC_ID_DONE: begin
        if (p_mode == MODE_INIT) begin
          p_mode      = MODE_DISARMED;
          p_last_sent = MODE_DISARMED;
        end
      end
      default: ;
    endcase

    m = p_mode;
    if (trip && m == MODE_ARMED) begin
      m    = MODE_INTRUSION;
      push = 1'b1;
    end
    if (pw_ok) begin
      if (m == MODE_DISARMED) m = MODE_ARMED;
      else if (m == MODE_ARMED || m == MODE_INTRUSION || m == MODE_ALARM) m = MODE_DISARMED;
      push = 1'b1;
    end else if (pw_bad && (m == MODE_ARMED || m == MODE_INTRUSION || m == MODE_ALARM)) begin
      if (p_wrong_cnt != WrongMax) p_wrong_cnt = p_wrong_cnt + 4'd1;
    end
    if (p_wrong_cnt > p_lim && (m == MODE_ARMED || m == MODE_INTRUSION)) begin
      m    = MODE_ALARM;
      push = 1'b1;
    end
    if (hb && (m == MODE_ARMED || m == MODE_INTRUSION)) begin
      m    = MODE_ALARM;
      push = 1'b1;
    end
    // adopt what the network last heard unless this request forced a mode
    if (p_last_sent != m && !push && !expired) m = p_last_sent;
    if (m != prev_m) begin
      if (m == MODE_DISARMED) begin
        p_wrong_cnt = '0;
      end else if (m == MODE_INTRUSION) begin
        p_dly_cnt = p_dly;
        p_dly_run = 1'b1;
      end
    end
    if (m != p_last_sent) begin
      send        = (m != MODE_INIT);
      p_last_sent = m;
    end
    p_mode = m;

    r.mode            = m;
    r.send_msg        = send;
    r.msg_node        = send ? p_nid : 8'd0;
    r.siren_on        = (m == MODE_ALARM);
    r.keypad_feedback = fb;
    r.entry_active    = (p_typed != 3'd0);
    return r;
  endfunction

  // Score results, keep the register copies and predict each accepted request.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      p_mode      = MODE_INIT;
      p_last_sent = MODE_INIT;
      p_wrong_cnt = '0;
      p_smp_prev  = NoKey;
      p_smp_prev2 = NoKey;
      p_typed     = '0;
      p_dly_cnt   = '0;
      p_dly_run   = 1'b0;
      p_pw        = '0;
      p_dly       = DelayRst;
      p_lim       = LimitRst;
      p_nid       = '0;
      for (int i = 0; i < EntryLen; i++) p_digits[i] = '0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_mode, out_send_msg, out_msg_node, out_siren_on,
                out_keypad_feedback, out_entry_active};
        n_results++;
        if (got.send_msg) n_bcast++;
        if (got.siren_on) n_siren++;
        if (mode_results_q.size() == 0) begin
          n_fail++;
          n_reports++;
          if (n_reports <= MaxReports)
            $display("%0t: result with nothing outstanding: mode %0d fb %0d", $realtime,
                     got.mode, got.keypad_feedback);
        end else begin
          want = mode_results_q.pop_front();
          if (got.mode !== want.mode || got.send_msg !== want.send_msg ||
              got.msg_node !== want.msg_node || got.siren_on !== want.siren_on ||
              got.keypad_feedback !== want.keypad_feedback ||
              got.entry_active !== want.entry_active) begin
            n_fail++;
            n_reports++;
            if (n_reports <= MaxReports)
              $display({"%0t: result %0d mismatch, exp mode %0d send %0d node %0d siren %0d ",
                        "fb %0d entry %0d, got mode %0d send %0d node %0d siren %0d fb %0d ",
                        "entry %0d"}, $realtime, n_results,
                       want.mode, want.send_msg, want.msg_node, want.siren_on,
                       want.keypad_feedback, want.entry_active,
                       got.mode, got.send_msg, got.msg_node, got.siren_on,
                       got.keypad_feedback, got.entry_active);
          end
        end
      end
      if (in_valid && in_stall) n_held++;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PASSWORD:    p_pw  = cfg_data;
          REG_DELAY:       p_dly = cfg_data;
          REG_WRONG_LIMIT: p_lim = cfg_data[3:0];
          REG_NODE_ID:     p_nid = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        want = predict_mode_step(in_func, in_key_present, in_key_code, in_reported_state);
        mode_results_q.push_back(drv_has_exp ? drv_exp : want);
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (pressure_req) begin
        pressure_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldOffCyc) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Present one request and hold it until taken; call at a rising edge.
  task automatic offer(input logic [2:0] f, input logic kp, input logic [3:0] kc,
                       input logic [2:0] rep, input logic has_exp, input result_t e);
    in_valid          <= 1'b1;
    in_func           <= f;
    in_key_present    <= kp;
    in_key_code       <= kc;
    in_reported_state <= rep;
    drv_has_exp       <= has_exp;
    drv_exp           <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_offered++;
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  task automatic offer_event(input logic [2:0] f);
    offer(f, 1'($urandom), 4'($urandom), 3'($urandom), 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mode_results_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [15:0] pw, input logic [15:0] dly,
                          input logic [3:0] lim, input logic [7:0] nid);
    drain();
    cur_pw = pw;
    cfg_write(REG_PASSWORD, pw);
    cfg_write(REG_DELAY, dly);
    cfg_write(REG_WRONG_LIMIT, {12'd0, lim});
    cfg_write(REG_NODE_ID, {8'd0, nid});
  endtask

  // Four debounced digits: press, hold, release; sometimes a stray sample first.
  task automatic type_entry();
    logic       all_ok;
    logic [3:0] d;
    all_ok = 1'($urandom_range(0, 1));
    for (int i = 0; i < EntryLen; i++) begin
      d = (all_ok || $urandom_range(0, 1) == 0) ? cur_pw[4*i +: 4] : 4'($urandom);
      if ($urandom_range(0, 7) == 0) offer(FUNC_KEY, 1'b1, 4'($urandom), 3'($urandom), 1'b0, '0);
      offer(FUNC_KEY, 1'b1, d, 3'($urandom), 1'b0, '0);
      offer(FUNC_KEY, 1'b1, d, 3'($urandom), 1'b0, '0);
      offer(FUNC_KEY, 1'b0, 4'($urandom), 3'($urandom), 1'b0, '0);
    end
  endtask

  task automatic run_phase(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = n_offered + n_items;
    while (n_offered < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 45)      type_entry();
      else if (pick < 57) offer_event(FUNC_TRIP);
      else if (pick < 64) offer_event(FUNC_HEARTBEAT);
      else if (pick < 80) repeat ($urandom_range(1, 12)) offer_event(FUNC_TICK);
      else if (pick < 89) offer_event(FUNC_REPORT);
      else if (pick < 93) offer_event(FUNC_ID_DONE);
      else if (pick < 96) offer_event(3'($urandom_range(FuncSpareLo, FuncSpareHi)));
      else                offer_event(FUNC_KEY);
    end
  endtask

  initial begin
    #(WatchdogNs);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_func           = '0;
    in_key_present    = 1'b0;
    in_key_code       = '0;
    in_reported_state = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    drv_has_exp       = 1'b0;
    drv_exp           = '0;
    idle_en           = 1'b1;
    pressure_req      = 1'b0;
    cur_pw            = '0;
    n_offered = 0; n_results = 0; n_fail = 0; n_reports = 0;
    n_held = 0; n_bcast = 0; n_siren = 0; n_cfg = 0;

    // reset register values: password all zeros, node 0
    dir_tbl[0]  = '{FUNC_TICK, 1'b0, 4'h0, 3'd0, 1'b1,
                    '{MODE_INIT, 1'b0, 8'd0, 1'b0, FB_NONE, 1'b0}};
    dir_tbl[1]  = '{FuncSpareHi, 1'b1, 4'hF, 3'd7, 1'b1,
                    '{MODE_INIT, 1'b0, 8'd0, 1'b0, FB_NONE, 1'b0}};
    dir_tbl[2]  = '{FUNC_REPORT, 1'b0, 4'h0, RepBadLo, 1'b1,
                    '{MODE_INIT, 1'b0, 8'd0, 1'b0, FB_NONE, 1'b0}};
    dir_tbl[3]  = '{FUNC_REPORT, 1'b0, 4'h0, RepBadHi, 1'b1,
                    '{MODE_INIT, 1'b0, 8'd0, 1'b0, FB_NONE, 1'b0}};
    dir_tbl[4]  = '{FUNC_HEARTBEAT, 1'b0, 4'h0, 3'd0, 1'b1,
                    '{MODE_INIT, 1'b0, 8'd0, 1'b0, FB_NONE, 1'b0}};
    dir_tbl[5]  = '{FUNC_ID_DONE, 1'b0, 4'h0, 3'd0, 1'b1,
                    '{MODE_DISARMED, 1'b0, 8'd0, 1'b0, FB_NONE, 1'b0}};
    dir_tbl[6]  = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b0, '0};
    dir_tbl[7]  = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b1,
                    '{MODE_DISARMED, 1'b0, 8'd0, 1'b0, FB_DIGIT1, 1'b1}};
    dir_tbl[8]  = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b0, '0};
    dir_tbl[9]  = '{FUNC_KEY, 1'b0, 4'hF, 3'd0, 1'b0, '0};
    dir_tbl[10] = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b0, '0};
    dir_tbl[11] = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b0, '0};
    dir_tbl[12] = '{FUNC_KEY, 1'b0, 4'hF, 3'd0, 1'b0, '0};
    dir_tbl[13] = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b0, '0};
    dir_tbl[14] = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b0, '0};
    dir_tbl[15] = '{FUNC_KEY, 1'b0, 4'hF, 3'd0, 1'b0, '0};
    dir_tbl[16] = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b0, '0};
    dir_tbl[17] = '{FUNC_KEY, 1'b1, 4'h0, 3'd0, 1'b1,
                    '{MODE_ARMED, 1'b1, 8'd0, 1'b0, FB_OK, 1'b0}};
    dir_tbl[18] = '{FUNC_TRIP, 1'b0, 4'h0, 3'd0, 1'b1,
                    '{MODE_INTRUSION, 1'b1, 8'd0, 1'b0, FB_NONE, 1'b0}};
    dir_tbl[19] = '{FUNC_HEARTBEAT, 1'b0, 4'h0, 3'd0, 1'b1,
                    '{MODE_ALARM, 1'b1, 8'd0, 1'b1, FB_NONE, 1'b0}};
    dir_tbl[20] = '{FUNC_REPORT, 1'b0, 4'h0, MODE_ARMED, 1'b0, '0};
    dir_tbl[21] = '{FUNC_TICK, 1'b1, 4'hF, 3'd7, 1'b0, '0};
    dir_tbl[22] = '{FUNC_KEY, 1'b1, 4'hF, 3'd0, 1'b0, '0};
    dir_tbl[23] = '{FUNC_KEY, 1'b1, 4'hF, 3'd0, 1'b0, '0};
    dir_tbl[24] = '{FUNC_ID_DONE, 1'b0, 4'h0, 3'd0, 1'b0, '0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i])
      offer(dir_tbl[i].func, dir_tbl[i].key_present, dir_tbl[i].key_code,
            dir_tbl[i].rep, dir_tbl[i].has_exp, dir_tbl[i].exp);

    set_regs(16'($urandom), 16'd3, 4'd0, 8'd255);
    // hold the result side off while requests keep coming
    pressure_req = 1'b1;
    run_phase(PhaseItems);
    set_regs(16'hFFFF, 16'd0, 4'd15, 8'd0);
    run_phase(PhaseItems);
    set_regs(16'h0000, 16'hFFFF, 4'd14, 8'($urandom));
    run_phase(PhaseItems);
    set_regs(16'($urandom), 16'd1, 4'd1, 8'($urandom));
    run_phase(PhaseItems);
    repeat (3) begin
      set_regs(16'($urandom), 16'($urandom_range(1, 10)), 4'($urandom_range(0, 3)),
               8'($urandom));
      run_phase(PhaseItems);
    end
    // closing stretch runs flat out on both sides
    set_regs(16'($urandom), 16'($urandom_range(1, 10)), 4'($urandom_range(0, 3)), 8'($urandom));
    idle_en = 1'b0;
    run_phase(PhaseItems);
    drain();
    repeat (10) @(posedge clk);
    n_fail += mode_results_q.size();

    $display("Covered %0d requests under %0d register writes: %0d results, %0d broadcasts, %0d in alarm",
             n_offered, n_cfg, n_results, n_bcast, n_siren);
    $display("Input held off for %0d cycles by output back-pressure; %0d failures", n_held,
             n_fail);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
